[rtl/pru_pkg.sv]
// Shared types, codes and reset values of the pump refill controller.
package pru_pkg;

    localparam int TIME_WIDTH_DEF = 20;
    localparam int LEVEL_W        = 7;
    localparam int CHECK_W        = 16;
    localparam int DUR_W          = 20;
    localparam int CFG_DATA_W     = 20;
    localparam int CFG_IDX_W      = 2;

    localparam logic [LEVEL_W-1:0] FULL_THR_RST  = 7'd90;
    localparam logic [LEVEL_W-1:0] RESV_THR_RST  = 7'd10;
    localparam logic [CHECK_W-1:0] CHECK_MS_RST  = 16'd500;
    localparam logic [DUR_W-1:0]   TIMEOUT_MS_RST = 20'd30000;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_START = 2'd1,
        MODE_STOP  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        RES_SUCCESS    = 3'd0,
        RES_SKIP_FULL  = 3'd1,
        RES_SKIP_EMPTY = 3'd2,
        RES_TIMEOUT    = 3'd3,
        RES_DRY_RUN    = 3'd4
    } t_rec_code;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FULL_THR   = 2'd0,
        CFG_RESV_THR   = 2'd1,
        CFG_CHECK_MS   = 2'd2,
        CFG_TIMEOUT_MS = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [LEVEL_W-1:0] full_thr;
        logic [LEVEL_W-1:0] resv_thr;
        logic [CHECK_W-1:0] check_ms;
        logic [DUR_W-1:0]   timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic               pumping;
        logic               done_flag;
        logic [CHECK_W-1:0] since_check;
        logic               rec_valid;
        logic [2:0]         rec_result;
        logic [LEVEL_W-1:0] rec_before;
        logic [LEVEL_W-1:0] rec_after;
        logic [DUR_W-1:0]   rec_duration;
    } t_run_state;

    typedef struct packed {
        logic [1:0]         mode;
        logic [LEVEL_W-1:0] bowl;
        logic               has_water;
        logic [LEVEL_W-1:0] resv;
        logic               sense;
    } t_item;

    typedef struct packed {
        logic               pump_on;
        logic               refilling;
        logic               complete;
        logic               start_acc;
        logic               stale;
        logic               rec_valid;
        logic [2:0]         rec_result;
        logic [LEVEL_W-1:0] lvl_before;
        logic [LEVEL_W-1:0] lvl_after;
        logic [DUR_W-1:0]   duration;
    } t_result;

endpackage

[rtl/pump_refill_controller_core.sv]
// Top level of the pump refill controller: input stage, run state and result buffer.
//
//   channel   direction  handshake             payload
//   input     in         i_valid / o_stall     i_mode, i_bowl_level, i_reservoir_*, i_pump_sense
//   result    out        o_valid / i_stall     o_pump_on ... o_duration_ms
//   config    in         i_cfg_we              i_cfg_addr, i_cfg_wdata
//
// Every item yields one result: it is held in the input register, then passes through
// the step logic into the result buffer.
// One item per cycle is sustained while results are taken; the run state is registered and fed back to the step logic.
// The two-entry result buffer lets input keep flowing while a result waits;
// input stalls only while the buffer is full and an item sits in the input register.
// Synchronous reset restores the register defaults and the idle run state.
module pump_refill_controller_core
    import pru_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_mode,
    input  logic [LEVEL_W-1:0]    i_bowl_level,
    input  logic                  i_reservoir_has_water,
    input  logic [LEVEL_W-1:0]    i_reservoir_percent,
    input  logic                  i_pump_sense,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_pump_on,
    output logic                  o_refilling,
    output logic                  o_complete,
    output logic                  o_start_accepted,
    output logic                  o_stale_stopped,
    output logic                  o_record_valid,
    output logic [2:0]            o_record_result,
    output logic [LEVEL_W-1:0]    o_level_before,
    output logic [LEVEL_W-1:0]    o_level_after,
    output logic [DUR_W-1:0]      o_duration_ms,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg                  r_cfg;
    t_run_state            r_state;
    t_run_state            n_state;
    logic [TIME_WIDTH-1:0] r_since_start;
    logic [TIME_WIDTH-1:0] n_since_start;
    t_item                 r_item;
    logic                  r_in_valid;
    t_result               step_result;
    t_result               r_out0;
    t_result               r_out1;
    logic [1:0]            r_cnt;
    logic                  in_xfer;
    logic                  advance;
    logic                  out_xfer;

    assign o_stall  = r_in_valid && (r_cnt == 2'd2);
    assign in_xfer  = i_valid && !o_stall;
    assign advance  = r_in_valid && (r_cnt != 2'd2);
    assign out_xfer = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.full_thr   <= FULL_THR_RST;
            r_cfg.resv_thr   <= RESV_THR_RST;
            r_cfg.check_ms   <= CHECK_MS_RST;
            r_cfg.timeout_ms <= TIMEOUT_MS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_FULL_THR:   r_cfg.full_thr   <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_RESV_THR:   r_cfg.resv_thr   <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_CHECK_MS:   r_cfg.check_ms   <= i_cfg_wdata[CHECK_W-1:0];
                CFG_TIMEOUT_MS: r_cfg.timeout_ms <= i_cfg_wdata[DUR_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.mode      <= i_mode;
            r_item.bowl      <= i_bowl_level;
            r_item.has_water <= i_reservoir_has_water;
            r_item.resv      <= i_reservoir_percent;
            r_item.sense     <= i_pump_sense;
        end
    end

    pru_step #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_step (
        .i_item        (r_item),
        .i_cfg         (r_cfg),
        .i_state       (r_state),
        .i_since_start (r_since_start),
        .o_state       (n_state),
        .o_since_start (n_since_start),
        .o_result      (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.pumping      <= 1'b0;
            r_state.done_flag    <= 1'b1;
            r_state.since_check  <= '0;
            r_state.rec_valid    <= 1'b0;
            r_state.rec_result   <= RES_SUCCESS;
            r_state.rec_before   <= '0;
            r_state.rec_after    <= '0;
            r_state.rec_duration <= '0;
            r_since_start        <= '0;
        end else if (advance) begin
            r_state       <= n_state;
            r_since_start <= n_since_start;
        end
    end

    // Result buffer: r_out0 is the head shown on the ports, r_out1 the skid entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            unique case ({advance, out_xfer})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (out_xfer && (r_cnt == 2'd2)) begin
            r_out0 <= r_out1;
        end else if (advance && ((r_cnt == 2'd0) || out_xfer)) begin
            r_out0 <= step_result;
        end else if (advance) begin
            r_out1 <= step_result;
        end
    end

    assign o_valid          = (r_cnt != 2'd0);
    assign o_pump_on        = r_out0.pump_on;
    assign o_refilling      = r_out0.refilling;
    assign o_complete       = r_out0.complete;
    assign o_start_accepted = r_out0.start_acc;
    assign o_stale_stopped  = r_out0.stale;
    assign o_record_valid   = r_out0.rec_valid;
    assign o_record_result  = r_out0.rec_result;
    assign o_level_before   = r_out0.lvl_before;
    assign o_level_after    = r_out0.lvl_after;
    assign o_duration_ms    = r_out0.duration;

endmodule

[rtl/pru_step.sv]
// Next-state and result logic for one item of the refill controller.
module pru_step
    import pru_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  t_item                 i_item,
    input  t_cfg                  i_cfg,
    input  t_run_state            i_state,
    input  logic [TIME_WIDTH-1:0] i_since_start,
    output t_run_state            o_state,
    output logic [TIME_WIDTH-1:0] o_since_start,
    output t_result               o_result
);

    localparam int CW = (TIME_WIDTH > DUR_W) ? TIME_WIDTH : DUR_W;
    localparam logic [CW-1:0] DUR_MAX_W = CW'({DUR_W{1'b1}});

    logic [TIME_WIDTH-1:0] ss_inc;
    logic [CHECK_W-1:0]    sc_inc;
    logic [CW-1:0]         ss_wide;
    logic [DUR_W-1:0]      dur_sat;
    logic                  accepted;
    logic                  stale;
    logic                  bowl_full;

    assign ss_inc    = (&i_since_start) ? i_since_start : i_since_start + 1'b1;
    assign sc_inc    = (&i_state.since_check) ? i_state.since_check
                                              : i_state.since_check + 1'b1;
    assign ss_wide   = CW'(ss_inc);
    assign dur_sat   = (ss_wide > DUR_MAX_W) ? {DUR_W{1'b1}} : ss_wide[DUR_W-1:0];
    assign bowl_full = (i_item.bowl >= i_cfg.full_thr);

    always_comb begin
        o_state       = i_state;
        o_since_start = i_since_start;
        accepted      = 1'b0;
        stale         = 1'b0;
        unique case (i_item.mode)
            MODE_START: begin
                if (i_state.pumping) begin
                    accepted = 1'b1;
                end else begin
                    // A new run clears the record and notes the starting level.
                    o_state.done_flag    = 1'b0;
                    o_state.rec_valid    = 1'b0;
                    o_state.rec_result   = RES_SUCCESS;
                    o_state.rec_after    = '0;
                    o_state.rec_duration = '0;
                    o_state.rec_before   = i_item.bowl;
                    priority if (bowl_full || !i_item.has_water) begin
                        o_state.rec_result = bowl_full ? RES_SKIP_FULL : RES_SKIP_EMPTY;
                        o_state.rec_after  = i_item.bowl;
                        o_state.rec_valid  = 1'b1;
                        o_state.done_flag  = 1'b1;
                    end else begin
                        o_since_start       = '0;
                        o_state.since_check = '0;
                        o_state.pumping     = 1'b1;
                        accepted            = 1'b1;
                    end
                end
            end
            MODE_STOP: begin
                o_state.pumping   = 1'b0;
                o_state.done_flag = 1'b1;
            end
            MODE_TICK: begin
                priority if (i_item.sense && !i_state.pumping) begin
                    stale = 1'b1;
                end else if (i_state.pumping) begin
                    o_since_start       = ss_inc;
                    o_state.since_check = sc_inc;
                    if (sc_inc >= i_cfg.check_ms) begin
                        o_state.since_check = '0;
                        priority if (bowl_full) begin
                            o_state.rec_result = RES_SUCCESS;
                        end else if (CW'(ss_inc) >= CW'(i_cfg.timeout_ms)) begin
                            o_state.rec_result = RES_TIMEOUT;
                        end else if (i_item.resv <= i_cfg.resv_thr) begin
                            o_state.rec_result = RES_DRY_RUN;
                        end
                        if (bowl_full || (CW'(ss_inc) >= CW'(i_cfg.timeout_ms))
                            || (i_item.resv <= i_cfg.resv_thr)) begin
                            o_state.rec_after    = i_item.bowl;
                            o_state.rec_duration = dur_sat;
                            o_state.rec_valid    = 1'b1;
                            o_state.pumping      = 1'b0;
                            o_state.done_flag    = 1'b1;
                        end
                    end
                end
            end
            default: begin
                // The unused mode leaves the state alone.
            end
        endcase
    end

    always_comb begin
        o_result.pump_on    = o_state.pumping;
        o_result.refilling  = o_state.pumping;
        o_result.complete   = o_state.done_flag;
        o_result.start_acc  = accepted;
        o_result.stale      = stale;
        o_result.rec_valid  = o_state.rec_valid;
        o_result.rec_result = o_state.rec_result;
        o_result.lvl_before = o_state.rec_before;
        o_result.lvl_after  = o_state.rec_after;
        o_result.duration   = o_state.rec_duration;
    end

endmodule

[rtl/pru_checker.sv]
// Port-level checks of the refill controller, bound to the top level.
module pru_checker
    import pru_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic               o_pump_on,
    input logic               o_refilling,
    input logic               o_complete,
    input logic               o_start_accepted,
    input logic               o_stale_stopped,
    input logic               o_record_valid,
    input logic [DUR_W-1:0]   o_duration_ms
);

    // The drive command and the refill status come from the same state bit.
    a_pump_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pump_on == o_refilling))
        else $error("pump_on and refilling disagree");

    // A running pump means a refill is pending.
    a_pump_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pump_on) |-> !o_complete)
        else $error("pump on while complete is set");

    // A finished record exists only once the run has ended.
    a_record_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_record_valid) |-> (o_complete && !o_pump_on))
        else $error("record valid during a run");

    // A tick that forces a stale pump off does nothing else.
    a_stale_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stale_stopped) |-> (!o_pump_on && !o_start_accepted))
        else $error("stale stop with pump on or start accepted");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_duration_ms)))
        else $error("stalled result changed");

endmodule

bind pump_refill_controller_core pru_checker u_pru_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_pump_on        (o_pump_on),
    .o_refilling      (o_refilling),
    .o_complete       (o_complete),
    .o_start_accepted (o_start_accepted),
    .o_stale_stopped  (o_stale_stopped),
    .o_record_valid   (o_record_valid),
    .o_duration_ms    (o_duration_ms)
);

[sim/pump_refill_checker.sv]
// Checker for the pump refill controller: predicts each result and compares it field by field.
module pump_refill_checker
    import pru_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [1:0]            i_mode,
    input  logic [LEVEL_W-1:0]    i_bowl_level,
    input  logic                  i_reservoir_has_water,
    input  logic [LEVEL_W-1:0]    i_reservoir_percent,
    input  logic                  i_pump_sense,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic                  i_pump_on,
    input  logic                  i_refilling,
    input  logic                  i_complete,
    input  logic                  i_start_accepted,
    input  logic                  i_stale_stopped,
    input  logic                  i_record_valid,
    input  logic [2:0]            i_record_result,
    input  logic [LEVEL_W-1:0]    i_level_before,
    input  logic [LEVEL_W-1:0]    i_level_after,
    input  logic [DUR_W-1:0]      i_duration_ms,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_fail_cnt,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIME_W      = TIME_WIDTH_DEF;
    localparam int MAX_REPORTS = 40;

    t_cfg               cfg;
    logic               pumping;
    logic               done_flag;
    logic [TIME_W-1:0]  since_start;
    logic [CHECK_W-1:0] since_check;
    logic               rec_valid;
    logic [2:0]         rec_result;
    logic [LEVEL_W-1:0] rec_before;
    logic [LEVEL_W-1:0] rec_after;
    logic [DUR_W-1:0]   rec_duration;

    t_result            expected_q[$];

    task automatic close_run(input t_rec_code code, input logic [LEVEL_W-1:0] level);
        longint unsigned run_ms;
        run_ms = 64'(since_start);
        rec_result = code;
        rec_after  = level;
        if (!pumping) begin
            rec_duration = '0;
        end else if (run_ms > longint'({DUR_W{1'b1}})) begin
            rec_duration = '1;
        end else begin
            rec_duration = run_ms[DUR_W-1:0];
        end
        rec_valid = 1'b1;
        pumping   = 1'b0;
        done_flag = 1'b1;
    endtask

    // Advances the run state by one transfer and returns the status it should report.
    task automatic step_refill(input logic [1:0] mode, input logic [LEVEL_W-1:0] bowl,
                               input logic water, input logic [LEVEL_W-1:0] resv,
                               input logic sense, output t_result res);
        logic accepted;
        logic stale;
        accepted = 1'b0;
        stale    = 1'b0;
        case (mode)
            MODE_START: begin
                if (pumping) begin
                    accepted = 1'b1;
                end else begin
                    done_flag    = 1'b0;
                    rec_valid    = 1'b0;
                    rec_result   = RES_SUCCESS;
                    rec_after    = '0;
                    rec_duration = '0;
                    rec_before   = bowl;
                    if (bowl >= cfg.full_thr) begin
                        close_run(RES_SKIP_FULL, bowl);
                    end else if (!water) begin
                        close_run(RES_SKIP_EMPTY, bowl);
                    end else begin
                        since_start = '0;
                        since_check = '0;
                        pumping     = 1'b1;
                        accepted    = 1'b1;
                    end
                end
            end
            MODE_STOP: begin
                pumping   = 1'b0;
                done_flag = 1'b1;
            end
            MODE_TICK: begin
                if (sense && !pumping) begin
                    stale = 1'b1;
                end else if (pumping) begin
                    if (since_start != '1) since_start = since_start + 1'b1;
                    if (since_check != '1) since_check = since_check + 1'b1;
                    if (since_check >= cfg.check_ms) begin
                        since_check = '0;
                        if (bowl >= cfg.full_thr) begin
                            close_run(RES_SUCCESS, bowl);
                        end else if (since_start >= cfg.timeout_ms) begin
                            close_run(RES_TIMEOUT, bowl);
                        end else if (resv <= cfg.resv_thr) begin
                            close_run(RES_DRY_RUN, bowl);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        res.pump_on    = pumping;
        res.refilling  = pumping;
        res.complete   = done_flag;
        res.start_acc  = accepted;
        res.stale      = stale;
        res.rec_valid  = rec_valid;
        res.rec_result = rec_result;
        res.lvl_before = rec_before;
        res.lvl_after  = rec_after;
        res.duration   = rec_duration;
    endtask

    task automatic note_failure(input string msg);
        o_fail_cnt++;
        if (o_fail_cnt <= MAX_REPORTS) $error("%s", msg);
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) note_failure($sformatf("%s: expected %0d, got %0d", name, want, got));
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            cfg.full_thr   = FULL_THR_RST;
            cfg.resv_thr   = RESV_THR_RST;
            cfg.check_ms   = CHECK_MS_RST;
            cfg.timeout_ms = TIMEOUT_MS_RST;
            pumping        = 1'b0;
            done_flag      = 1'b1;
            since_start    = '0;
            since_check    = '0;
            rec_valid      = 1'b0;
            rec_result     = RES_SUCCESS;
            rec_before     = '0;
            rec_after      = '0;
            rec_duration   = '0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_FULL_THR:   cfg.full_thr   = i_cfg_wdata[LEVEL_W-1:0];
                    CFG_RESV_THR:   cfg.resv_thr   = i_cfg_wdata[LEVEL_W-1:0];
                    CFG_CHECK_MS:   cfg.check_ms   = i_cfg_wdata[CHECK_W-1:0];
                    CFG_TIMEOUT_MS: cfg.timeout_ms = i_cfg_wdata[DUR_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    note_failure("result transfer with no item outstanding");
                end else begin
                    want = expected_q.pop_front();
                    check_field("pump_on", want.pump_on, i_pump_on);
                    check_field("refilling", want.refilling, i_refilling);
                    check_field("complete", want.complete, i_complete);
                    check_field("start_accepted", want.start_acc, i_start_accepted);
                    check_field("stale_stopped", want.stale, i_stale_stopped);
                    check_field("record_valid", want.rec_valid, i_record_valid);
                    check_field("record_result", want.rec_result, i_record_result);
                    check_field("level_before", want.lvl_before, i_level_before);
                    check_field("level_after", want.lvl_after, i_level_after);
                    check_field("duration_ms", want.duration, i_duration_ms);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                step_refill(i_mode, i_bowl_level, i_reservoir_has_water,
                            i_reservoir_percent, i_pump_sense, want);
                expected_q.push_back(want);
            end
        end
        o_pending <= expected_q.size();
    end

endmodule

[sim/testbench.sv]
// Top of the pump refill controller simulation: clock, reset, stimulus and verdict.
module testbench;
    import pru_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 80;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [1:0]            i_mode = MODE_TICK;
    logic [LEVEL_W-1:0]    i_bowl_level = '0;
    logic                  i_reservoir_has_water = 1'b0;
    logic [LEVEL_W-1:0]    i_reservoir_percent = '0;
    logic                  i_pump_sense = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_pump_on;
    logic                  o_refilling;
    logic                  o_complete;
    logic                  o_start_accepted;
    logic                  o_stale_stopped;
    logic                  o_record_valid;
    logic [2:0]            o_record_result;
    logic [LEVEL_W-1:0]    o_level_before;
    logic [LEVEL_W-1:0]    o_level_after;
    logic [DUR_W-1:0]      o_duration_ms;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = CFG_FULL_THR;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    int fail_cnt;
    int pending_cnt;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycle_cnt = 0;
    int items_sent = 0;
    int cur_full = int'(FULL_THR_RST);

    pump_refill_controller_core u_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_mode                (i_mode),
        .i_bowl_level          (i_bowl_level),
        .i_reservoir_has_water (i_reservoir_has_water),
        .i_reservoir_percent   (i_reservoir_percent),
        .i_pump_sense          (i_pump_sense),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_pump_on             (o_pump_on),
        .o_refilling           (o_refilling),
        .o_complete            (o_complete),
        .o_start_accepted      (o_start_accepted),
        .o_stale_stopped       (o_stale_stopped),
        .o_record_valid        (o_record_valid),
        .o_record_result       (o_record_result),
        .o_level_before        (o_level_before),
        .o_level_after         (o_level_after),
        .o_duration_ms         (o_duration_ms),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_addr            (i_cfg_addr),
        .i_cfg_wdata           (i_cfg_wdata)
    );

    pump_refill_checker u_checker (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_valid),
        .i_in_stall            (o_stall),
        .i_mode                (i_mode),
        .i_bowl_level          (i_bowl_level),
        .i_reservoir_has_water (i_reservoir_has_water),
        .i_reservoir_percent   (i_reservoir_percent),
        .i_pump_sense          (i_pump_sense),
        .i_out_valid           (o_valid),
        .i_out_stall           (i_stall),
        .i_pump_on             (o_pump_on),
        .i_refilling           (o_refilling),
        .i_complete            (o_complete),
        .i_start_accepted      (o_start_accepted),
        .i_stale_stopped       (o_stale_stopped),
        .i_record_valid        (o_record_valid),
        .i_record_result       (o_record_result),
        .i_level_before        (o_level_before),
        .i_level_after         (o_level_after),
        .i_duration_ms         (o_duration_ms),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_addr            (i_cfg_addr),
        .i_cfg_wdata           (i_cfg_wdata),
        .o_fail_cnt            (fail_cnt),
        .o_pending             (pending_cnt)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: random stalls, or a long hold-off each time the stimulus asks for one.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic int rand_level();
        if ($urandom_range(9) == 0) return $urandom_range(127);
        return $urandom_range(100);
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    // Valid stays high from one transfer to the next unless an idle cycle is drawn.
    task automatic send_item(input logic [1:0] mode, input int bowl, input logic water,
                             input int resv, input logic sense);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid               <= 1'b1;
        i_mode                <= mode;
        i_bowl_level          <= LEVEL_W'(bowl);
        i_reservoir_has_water <= water;
        i_reservoir_percent   <= LEVEL_W'(resv);
        i_pump_sense          <= sense;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (mode != MODE_UNUSED) items_sent++;
    endtask

    task automatic set_regs(input int full, input int resv, input int check, input int timeout);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_FULL_THR;
        i_cfg_wdata <= CFG_DATA_W'(full);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_RESV_THR;
        i_cfg_wdata <= CFG_DATA_W'(resv);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_CHECK_MS;
        i_cfg_wdata <= CFG_DATA_W'(check);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_TIMEOUT_MS;
        i_cfg_wdata <= CFG_DATA_W'(timeout);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_full = full;
    endtask

    task automatic settle(input int pause);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (pause) @(posedge i_clk);
    endtask

    // A start with water, the bowl under a nonzero full threshold, then ticks with the bowl
    // filling and reservoir draining, among stops and restarts, then up to three random ticks.
    task automatic refill_episode();
        int bowl;
        int resv;
        int pick;
        if (cur_full == 0) bowl = 0;
        else if (cur_full > 100) bowl = $urandom_range(100);
        else bowl = $urandom_range(cur_full - 1);
        resv = $urandom_range(100);
        send_item(MODE_START, bowl, 1'b1, resv, rand_bit());
        repeat ($urandom_range(40, 1)) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                send_item(MODE_STOP, bowl, rand_bit(), resv, rand_bit());
            end else if (pick < 8) begin
                send_item(MODE_START, rand_level(), rand_bit(), resv, rand_bit());
            end else begin
                bowl = bowl + $urandom_range(3);
                if (bowl > 100) bowl = 100;
                resv = resv - $urandom_range(2);
                if (resv < 0) resv = 0;
                send_item(MODE_TICK, bowl, rand_bit(), resv, rand_bit());
            end
        end
        repeat ($urandom_range(3)) begin
            send_item(MODE_TICK, rand_level(), rand_bit(), rand_level(), rand_bit());
        end
    endtask

    task automatic run_phase(input int n_items, input int idle, input int stall,
                             input bit squeeze);
        int stop_at;
        send_idle_pct = idle;
        stall_pct <= stall;
        if (squeeze) hold_req <= hold_req + 1;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(3) == 0) begin
                send_item(2'($urandom_range(3)), rand_level(), rand_bit(), rand_level(),
                          rand_bit());
            end else begin
                refill_episode();
            end
        end
        settle(4);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: skips, stale pump, idle stop, unused mode, start while pumping.
        send_item(MODE_START, 90, 1'b1, 50, 1'b0);
        send_item(MODE_START, 127, 1'b0, 127, 1'b1);
        send_item(MODE_START, 0, 1'b0, 0, 1'b0);
        send_item(MODE_TICK, 0, 1'b0, 0, 1'b1);
        send_item(MODE_STOP, 0, 1'b0, 0, 1'b0);
        send_item(MODE_UNUSED, 127, 1'b1, 127, 1'b1);
        send_item(MODE_START, 89, 1'b1, 100, 1'b0);
        send_item(MODE_START, 0, 1'b0, 0, 1'b1);
        send_item(MODE_TICK, 89, 1'b1, 100, 1'b1);
        send_item(MODE_STOP, 89, 1'b1, 100, 1'b1);
        settle(4);

        // A zero interval samples on every tick: timeout, success, dry run, and success
        // taking priority over a dry reservoir.
        set_regs(50, 20, 0, 3);
        send_item(MODE_START, 10, 1'b1, 100, 1'b0);
        repeat (3) send_item(MODE_TICK, 10, 1'b1, 100, 1'b0);
        send_item(MODE_START, 49, 1'b1, 100, 1'b0);
        send_item(MODE_TICK, 50, 1'b1, 100, 1'b0);
        send_item(MODE_START, 0, 1'b1, 0, 1'b0);
        send_item(MODE_TICK, 0, 1'b1, 20, 1'b0);
        send_item(MODE_START, 0, 1'b1, 0, 1'b0);
        send_item(MODE_TICK, 100, 1'b1, 0, 1'b0);
        settle(4);

        // Timeout wins over a dry reservoir when the first sample comes late.
        set_regs(50, 20, 4, 2);
        send_item(MODE_START, 0, 1'b1, 0, 1'b0);
        repeat (4) send_item(MODE_TICK, 0, 1'b1, 0, 1'b0);
        settle(4);

        set_regs(60, 15, 3, 25);
        run_phase(300, 0, 0, 1'b0);
        set_regs(90, 10, 1, 1);
        run_phase(250, 52, 0, 1'b0);
        set_regs(127, 127, 5, 40);
        run_phase(250, 0, 52, 1'b0);
        set_regs(0, 0, 2, 10);
        run_phase(100, 30, 30, 1'b0);
        set_regs(75, 30, 0, 1048575);
        run_phase(250, 30, 30, 1'b0);
        set_regs(80, 5, 65535, 1048575);
        run_phase(150, 0, 0, 1'b0);
        set_regs(70, 20, 4, 30);
        run_phase(200, 0, 0, 1'b1);
        set_regs(int'(FULL_THR_RST), int'(RESV_THR_RST), int'(CHECK_MS_RST),
                 int'(TIMEOUT_MS_RST));
        run_phase(130, 30, 30, 1'b0);

        settle(10);
        if (fail_cnt == 0 && pending_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[pump_refill_controller_core.f]
rtl/pru_pkg.sv
rtl/pru_step.sv
rtl/pump_refill_controller_core.sv
rtl/pru_checker.sv
sim/pump_refill_checker.sv
sim/testbench.sv
